// ===== src/slrf_pkg.sv =====
// Shared types, constants and the sRGB linearization table for the lightness range filter.
`default_nettype none

package slrf_pkg;

    // Field and datapath widths.
    localparam int unsigned TAG_W   = 16;
    localparam int unsigned CHAN_W  = 8;
    localparam int unsigned LIN_W   = 17;
    localparam int unsigned Y_W     = 17;
    localparam int unsigned LIGHT_W = 15;
    localparam int unsigned ROOT_W  = 21;
    localparam int unsigned SQ_W    = 2 * ROOT_W;
    localparam int unsigned TGT_W   = 63;
    localparam int unsigned AUX_W   = 18;
    localparam int unsigned CFG_W   = 15;
    localparam int unsigned LIN_N   = 2 ** CHAN_W;

    // Luminance weights in Q0.16 and the rounding offset.
    localparam logic [13:0] LUMA_R   = 14'd13933;
    localparam logic [15:0] LUMA_G   = 16'd46871;
    localparam logic [12:0] LUMA_B   = 13'd4732;
    localparam logic [15:0] LUMA_RND = 16'd32768;

    // Linear segment of f(): 116 * 7.787 scaled, plus its rounding offset.
    localparam logic [Y_W-1:0] LIN_LIMIT = 17'd580;
    localparam logic [19:0]    LIN_MUL   = 20'd903292;
    localparam logic [16:0]    LIN_RND   = 17'd128000;
    // Reciprocal of 125 in Q25; exact floor for numerators below 2^18.
    localparam logic [18:0]    LIN_RECIP = 19'd268436;

    // Cube-root segment: 116 in Q8 applied to f in Q21, minus 16 in Q8.
    localparam logic [14:0] CBRT_SCALE  = 15'd29696;
    localparam logic [15:0] CBRT_OFFSET = 16'd4096;

    localparam logic [LIGHT_W-1:0] LIGHT_MAX = 15'd25600;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_MIN_LIGHTNESS = 1'b0,
        CFG_MAX_LIGHTNESS = 1'b1
    } t_cfg_idx;

    // Input and result words.
    typedef struct packed {
        logic [TAG_W-1:0]  row_tag;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_pix_in;

    typedef struct packed {
        logic [TAG_W-1:0]   row_tag_out;
        logic [LIGHT_W-1:0] lightness;
        logic               accepted;
    } t_pix_out;

    // Word carried through the cube-root stages.
    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic              full;
        logic              lin;
        logic [AUX_W-1:0]  aux;
        logic [TGT_W-1:0]  target;
        logic [ROOT_W-1:0] res;
        logic [SQ_W-1:0]   sq;
        logic [TGT_W-1:0]  cube;
    } t_root;

    typedef logic [LIN_N-1:0][LIN_W-1:0] t_lin_tbl;

    // Fifth power in Q30, truncating after each product.
    function automatic logic [63:0] pow5_q30(input logic [63:0] r);
        logic [63:0] p;
        p = r;
        for (int i = 0; i < 4; i++) begin
            p = (p * r) >> 30;
        end
        return p;
    endfunction

    // Floor fifth root in Q30, one bit per step.
    function automatic logic [63:0] root5_q30(input logic [63:0] u);
        logic [63:0] res;
        logic [63:0] cand;
        res = 64'd0;
        if (u >= (64'd1 << 30)) begin
            return 64'd1 << 30;
        end
        for (int b = 29; b >= 0; b--) begin
            cand = res | (64'd1 << b);
            if (pow5_q30(cand) <= u) begin
                res = cand;
            end
        end
        return res;
    endfunction

    // sRGB gamma expansion of one byte to Q0.16.
    function automatic logic [LIN_W-1:0] lin_value(input logic [63:0] c);
        logic [63:0] t;
        logic [63:0] u;
        logic [63:0] r;
        logic [63:0] x;
        logic [63:0] v;
        if (c <= 64'd10) begin
            v = (c * 64'd6553600 + 64'd164730) / 64'd329460;
        end else begin
            t = ((64'd1000 * c + 64'd14025) << 30) / 64'd269025;
            u = (t * t) >> 30;
            r = root5_q30(u);
            x = (u * r) >> 30;
            v = (x + 64'd8192) >> 14;
        end
        return v[LIN_W-1:0];
    endfunction

    function automatic t_lin_tbl build_lin_tbl();
        t_lin_tbl tbl;
        for (int i = 0; i < LIN_N; i++) begin
            tbl[i] = lin_value(64'(i));
        end
        return tbl;
    endfunction

    localparam t_lin_tbl LIN_TBL = build_lin_tbl();

endpackage

`default_nettype wire

// ===== src/slrf_front.sv =====
// Front stages: input register, gamma lookup, luminance sum and cube-root setup.
`default_nettype none

module slrf_front import slrf_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  logic    i_valid,
    input  t_pix_in i_pix,
    output logic    o_valid,
    output t_root   o_root
);

    logic [3:0]       r_valid;
    t_pix_in          r_pix;
    logic [TAG_W-1:0] r_tag2;
    logic [LIN_W-1:0] r_lin_r;
    logic [LIN_W-1:0] r_lin_g;
    logic [LIN_W-1:0] r_lin_b;
    logic [TAG_W-1:0] r_tag3;
    logic [Y_W-1:0]   r_y;
    t_root            r_root;

    logic [32:0]    luma_sum;
    logic [Y_W-1:0] n_y;
    logic [29:0]    lin_num;
    t_root          n_root;

    // Weighted sum of the linear channels, rounded to Q0.16.
    always_comb begin
        luma_sum = 33'(LUMA_R) * 33'(r_lin_r) + 33'(LUMA_G) * 33'(r_lin_g)
                 + 33'(LUMA_B) * 33'(r_lin_b) + 33'(LUMA_RND);
        n_y = luma_sum[32:16];
    end

    // Seed the root search; the linear segment numerator is prescaled by 2^-11.
    always_comb begin
        lin_num       = 30'(LIN_MUL) * 30'(r_y[9:0]) + 30'(LIN_RND);
        n_root        = '0;
        n_root.tag    = r_tag3;
        n_root.full   = r_y[Y_W-1];
        n_root.lin    = (r_y <= LIN_LIMIT);
        n_root.aux    = lin_num[28:11];
        n_root.target = {r_y[Y_W-2:0], 47'd0};
    end

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[2:0], i_valid};
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pix   <= i_pix;
            r_tag2  <= r_pix.row_tag;
            r_lin_r <= LIN_TBL[r_pix.red];
            r_lin_g <= LIN_TBL[r_pix.green];
            r_lin_b <= LIN_TBL[r_pix.blue];
            r_tag3  <= r_tag2;
            r_y     <= n_y;
            r_root  <= n_root;
        end
    end

    assign o_valid = r_valid[3];
    assign o_root  = r_root;

endmodule

`default_nettype wire

// ===== src/slrf_cbrt_step.sv =====
// One registered step of the bitwise cube root, deciding a single result bit.
`default_nettype none

module slrf_cbrt_step import slrf_pkg::*; #(
    parameter int unsigned BIT = 0
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_root i_root,
    output logic  o_valid,
    output t_root o_root
);

    logic        r_valid;
    t_root       r_root;

    logic [63:0] inc;
    logic [63:0] cand_cube;
    t_root       n_root;

    // (res + 2^b)^3 from the running square and cube, using shifts and adds.
    always_comb begin
        inc = ((64'(i_root.sq) * 64'd3) << BIT)
            + ((64'(i_root.res) * 64'd3) << (2 * BIT))
            + (64'd1 << (3 * BIT));
        cand_cube = 64'(i_root.cube) + inc;
        n_root = i_root;
        if (cand_cube <= 64'(i_root.target)) begin
            n_root.res  = i_root.res | (ROOT_W'(1) << BIT);
            n_root.sq   = i_root.sq + (SQ_W'(i_root.res) << (BIT + 1))
                        + (SQ_W'(1) << (2 * BIT));
            n_root.cube = cand_cube[TGT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_root <= n_root;
        end
    end

    assign o_valid = r_valid;
    assign o_root  = r_root;

endmodule

`default_nettype wire

// ===== src/slrf_back.sv =====
// Back stages: lightness from either segment of f(), then clamp, range test and result register.
`default_nettype none

module slrf_back import slrf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  t_root            i_root,
    input  logic [CFG_W-1:0] i_min_lightness,
    input  logic [CFG_W-1:0] i_max_lightness,
    output logic             o_valid,
    output t_pix_out         o_pix
);

    logic             r_valid;
    logic [TAG_W-1:0] r_tag;
    logic [15:0]      r_light;
    logic             r_out_valid;
    t_pix_out         r_out;

    logic [ROOT_W:0]    cbrt_val;
    logic [36:0]        cbrt_prod;
    logic [15:0]        cbrt_v;
    logic [36:0]        lin_prod;
    logic [15:0]        n_light;
    logic [LIGHT_W-1:0] light_sat;
    t_pix_out           n_out;

    // Lightness from the cube root or from the linear segment.
    always_comb begin
        cbrt_val  = i_root.full ? ((ROOT_W + 1)'(1) << ROOT_W) : {1'b0, i_root.res};
        cbrt_prod = 37'(CBRT_SCALE) * 37'(cbrt_val) + (37'd1 << 20);
        cbrt_v    = cbrt_prod[36:21];
        lin_prod  = 37'(i_root.aux) * 37'(LIN_RECIP);
        if (i_root.lin) begin
            n_light = 16'(lin_prod[36:25]);
        end else if (cbrt_v > CBRT_OFFSET) begin
            n_light = cbrt_v - CBRT_OFFSET;
        end else begin
            n_light = '0;
        end
    end

    // Clamp to 100 and test against the exclusive bounds.
    always_comb begin
        light_sat = (r_light > 16'(LIGHT_MAX)) ? LIGHT_MAX : r_light[LIGHT_W-1:0];
        n_out.row_tag_out = r_tag;
        n_out.lightness   = light_sat;
        n_out.accepted    = (light_sat > i_min_lightness) && (light_sat < i_max_lightness);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (i_en) begin
            r_valid     <= i_valid;
            r_out_valid <= r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tag   <= i_root.tag;
            r_light <= n_light;
            r_out   <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_pix   = r_out;

endmodule

`default_nettype wire

// ===== src/srgb_lightness_range_filter.sv =====
// Top level of the sRGB lightness range filter.
//
// Each input word is one 8-bit sRGB pixel with a row tag. The block returns one
// result word per pixel: the tag, CIE L* in units of 1/256 (0..25600) and a flag
// that is set when min_lightness < L* < max_lightness. A new word is taken every
// clock while the pipeline is not halted. A word passes through 27 registers: four
// front stages (input register, gamma table, luminance, cube-root setup), the 21
// one-bit stages of the cube root and two back stages (lightness, then clamp and
// range test). The pipeline moves as a whole and halts only while the result
// register is full and not taken. Bounds are written through the plain write
// port (index 0 min, index 1 max); the user must write them only while no word
// is in flight, which the block itself does not enforce.
`default_nettype none

module srgb_lightness_range_filter import slrf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_pix_in          i_in_pix,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_pix_out         o_out_pix,
    input  logic             i_cfg_wr_en,
    input  logic             i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data
);

    logic [CFG_W-1:0] r_min_lightness;
    logic [CFG_W-1:0] r_max_lightness;

    logic             pipe_en;
    logic             out_valid;
    logic [ROOT_W:0]  stage_valid;
    t_root            stage_root [0:ROOT_W];

    // The whole pipeline advances unless a finished word is waiting.
    assign pipe_en     = !out_valid || i_out_ready;
    assign o_in_ready  = pipe_en;
    assign o_out_valid = out_valid;

    // Bound registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_lightness <= '0;
            r_max_lightness <= LIGHT_MAX;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_MIN_LIGHTNESS: r_min_lightness <= i_cfg_data;
                CFG_MAX_LIGHTNESS: r_max_lightness <= i_cfg_data;
                default: ;
            endcase
        end
    end

    slrf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (i_in_valid),
        .i_pix   (i_in_pix),
        .o_valid (stage_valid[0]),
        .o_root  (stage_root[0])
    );

    // Cube-root stages, most significant bit first.
    for (genvar g = 0; g < ROOT_W; g++) begin : g_cbrt
        slrf_cbrt_step #(
            .BIT (ROOT_W - 1 - g)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (pipe_en),
            .i_valid (stage_valid[g]),
            .i_root  (stage_root[g]),
            .o_valid (stage_valid[g+1]),
            .o_root  (stage_root[g+1])
        );
    end

    slrf_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (pipe_en),
        .i_valid         (stage_valid[ROOT_W]),
        .i_root          (stage_root[ROOT_W]),
        .i_min_lightness (r_min_lightness),
        .i_max_lightness (r_max_lightness),
        .o_valid         (out_valid),
        .o_pix           (o_out_pix)
    );

endmodule

`default_nettype wire

// ===== tb/sv/srgb_lightness_range_filter_test.sv =====
// Self-checking testbench for the sRGB lightness range filter.
`timescale 1ns / 1ps

module srgb_lightness_range_filter_test;
    import slrf_pkg::*;

    localparam int unsigned PHASES      = 6;
    localparam int unsigned PHASE_WORDS = 122;
    localparam int unsigned HOLD_AT     = 330;
    localparam int unsigned HOLD_LEN    = 200;
    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned DRAIN_WAIT  = 40;

    // One row of the directed table; light and ok are used only when typed is set.
    typedef struct packed {
        logic [15:0] tag;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic        typed;
        logic [14:0] light;
        logic        ok;
    } dir_row_t;

    logic        i_clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    t_pix_in     in_pix = '0;
    logic        out_ready = 1'b0;
    logic        cfg_wr_en = 1'b0;
    t_cfg_idx    cfg_index = CFG_MIN_LIGHTNESS;
    logic [14:0] cfg_data = '0;
    logic        o_in_ready;
    logic        o_out_valid;
    t_pix_out    o_out_pix;

    // Bounds as the block holds them, and the sRGB gamma curve in Q0.16.
    logic [14:0] lo_bound = 15'd0;
    logic [14:0] hi_bound = LIGHT_MAX;
    logic [16:0] gamma_lut [256];

    t_pix_out    awaited_out [$];
    bit          calm = 1'b0;
    int unsigned n_errors = 0;
    int unsigned n_sent = 0;
    int unsigned n_checked = 0;
    int unsigned n_inside = 0;
    int unsigned n_settings = 0;
    int unsigned light_lo = 32767;
    int unsigned light_hi = 0;

    // Directed words: black and white at reset bounds have known results.
    dir_row_t dir_rows [20] = '{
        {16'h0000, 8'd0,   8'd0,   8'd0,   1'b1, 15'd0,     1'b0},
        {16'hFFFF, 8'd255, 8'd255, 8'd255, 1'b1, 15'd25600, 1'b0},
        {16'h0001, 8'd255, 8'd0,   8'd0,   1'b0, 15'd0,     1'b0},
        {16'h0002, 8'd0,   8'd255, 8'd0,   1'b0, 15'd0,     1'b0},
        {16'h0003, 8'd0,   8'd0,   8'd255, 1'b0, 15'd0,     1'b0},
        {16'h0004, 8'd10,  8'd10,  8'd10,  1'b0, 15'd0,     1'b0},
        {16'h0005, 8'd11,  8'd11,  8'd11,  1'b0, 15'd0,     1'b0},
        {16'h0006, 8'd1,   8'd0,   8'd0,   1'b0, 15'd0,     1'b0},
        {16'h0007, 8'd0,   8'd0,   8'd1,   1'b0, 15'd0,     1'b0},
        {16'h0008, 8'd23,  8'd23,  8'd23,  1'b0, 15'd0,     1'b0},
        {16'h0009, 8'd24,  8'd24,  8'd24,  1'b0, 15'd0,     1'b0},
        {16'h000A, 8'd25,  8'd25,  8'd25,  1'b0, 15'd0,     1'b0},
        {16'h000B, 8'd26,  8'd26,  8'd26,  1'b0, 15'd0,     1'b0},
        {16'h5555, 8'h55,  8'hAA,  8'h55,  1'b0, 15'd0,     1'b0},
        {16'hAAAA, 8'hAA,  8'h55,  8'hAA,  1'b0, 15'd0,     1'b0},
        {16'h00FF, 8'd254, 8'd254, 8'd254, 1'b0, 15'd0,     1'b0},
        {16'hFF00, 8'd128, 8'd128, 8'd128, 1'b0, 15'd0,     1'b0},
        {16'h1234, 8'd0,   8'd255, 8'd255, 1'b0, 15'd0,     1'b0},
        {16'h8000, 8'd255, 8'd255, 8'd0,   1'b0, 15'd0,     1'b0},
        {16'h7FFF, 8'd255, 8'd0,   8'd255, 1'b0, 15'd0,     1'b0}
    };

    srgb_lightness_range_filter DUT (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_pix    (in_pix),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_pix   (o_out_pix),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Fifth power of a Q30 value, truncated after every product.
    function automatic logic [63:0] fifth_power_q30(input logic [63:0] r);
        logic [63:0] acc;
        acc = r;
        repeat (4) acc = (acc * r) >> 30;
        return acc;
    endfunction

    // Largest Q30 value whose truncated fifth power does not exceed u.
    function automatic logic [63:0] fifth_root_q30(input logic [63:0] u);
        logic [63:0] root;
        logic [63:0] trial;
        root = 64'd0;
        if (u >= (64'd1 << 30)) begin
            return 64'd1 << 30;
        end
        for (int b = 29; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (fifth_power_q30(trial) <= u) begin
                root = trial;
            end
        end
        return root;
    endfunction

    // sRGB byte to linear light in Q0.16; x^2.4 is formed as x^2 times x^0.4.
    function automatic logic [16:0] gamma_expand(input logic [7:0] c);
        logic [63:0] cw;
        logic [63:0] base;
        logic [63:0] sq;
        logic [63:0] prod;
        cw = {56'd0, c};
        if (cw <= 64'd10) begin
            return 17'((cw * 64'd6553600 + 64'd164730) / 64'd329460);
        end
        base = ((64'd1000 * cw + 64'd14025) << 30) / 64'd269025;
        sq   = (base * base) >> 30;
        prod = (sq * fifth_root_q30(sq)) >> 30;
        return 17'((prod + 64'd8192) >> 14);
    endfunction

    // Largest Q21 value whose cube does not exceed y in Q0.16.
    function automatic logic [63:0] cube_root_q21(input logic [63:0] y);
        logic [63:0] goal;
        logic [63:0] root;
        logic [63:0] trial;
        root = 64'd0;
        if (y >= 64'd65536) begin
            return 64'd1 << 21;
        end
        goal = y << 47;
        for (int b = 20; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial * trial <= goal) begin
                root = trial;
            end
        end
        return root;
    endfunction

    // Result word for one pixel under the current bounds.
    function automatic t_pix_out predict_pix(input t_pix_in pix);
        logic [63:0] luma;
        logic [63:0] scaled;
        logic [63:0] light;
        t_pix_out    res;
        luma = (64'd13933 * gamma_lut[pix.red] + 64'd46871 * gamma_lut[pix.green]
                + 64'd4732 * gamma_lut[pix.blue] + 64'd32768) >> 16;
        if (luma > 64'd580) begin
            scaled = (64'd29696 * cube_root_q21(luma) + (64'd1 << 20)) >> 21;
            light  = (scaled > 64'd4096) ? scaled - 64'd4096 : 64'd0;
        end else begin
            light = (64'd903292 * luma + 64'd128000) / 64'd256000;
        end
        if (light > LIGHT_MAX) begin
            light = LIGHT_MAX;
        end
        res.row_tag_out = pix.row_tag;
        res.lightness   = light[14:0];
        res.accepted    = (light > lo_bound) && (light < hi_bound);
        return res;
    endfunction

    // Random pixel: often uniform, otherwise grays, dark values, extremes or grays near bounds.
    function automatic t_pix_in random_pixel();
        t_pix_in     pix;
        int unsigned kind;
        logic [7:0]  level;
        kind        = $urandom_range(99);
        pix.row_tag = 16'($urandom);
        pix.red     = 8'($urandom);
        pix.green   = 8'($urandom);
        pix.blue    = 8'($urandom);
        if (kind < 45) begin
            return pix;
        end else if (kind < 65) begin
            level = 8'($urandom);
            pix.red = level;
            pix.green = level;
            pix.blue = level;
        end else if (kind < 80) begin
            pix.red   = 8'($urandom_range(30));
            pix.green = 8'($urandom_range(30));
            pix.blue  = 8'($urandom_range(30));
        end else if (kind < 90) begin
            if ($urandom_range(2) != 0) pix.red = $urandom_range(1) ? 8'd255 : 8'd0;
            if ($urandom_range(2) != 0) pix.green = $urandom_range(1) ? 8'd255 : 8'd0;
            if ($urandom_range(2) != 0) pix.blue = $urandom_range(1) ? 8'd255 : 8'd0;
        end else begin
            level = 8'($urandom_range(2) + ($urandom_range(1) ? 99 : 199));
            pix.red = level;
            pix.green = level;
            pix.blue = level;
        end
        return pix;
    endfunction

    task automatic flag_failure(input string msg);
        n_errors++;
        if (n_errors <= 10) begin
            $display("%s", msg);
        end
    endtask

    // Offer one word and record its expected result once it is taken.
    task automatic push_pixel(input t_pix_in pix, input bit typed, input t_pix_out want);
        while (!calm && $urandom_range(99) < 9) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_pix   <= pix;
        do @(posedge i_clk); while (!o_in_ready);
        awaited_out.push_back(typed ? want : predict_pix(pix));
        n_sent++;
    endtask

    // Stop offering and wait until every expected result has come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (awaited_out.size() != 0) @(posedge i_clk);
    endtask

    // Write both bounds; only called while nothing is in flight.
    task automatic set_bounds(input logic [14:0] lo, input logic [14:0] hi);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_MIN_LIGHTNESS;
        cfg_data  <= lo;
        lo_bound   = lo;
        @(posedge i_clk);
        cfg_index <= CFG_MAX_LIGHTNESS;
        cfg_data  <= hi;
        hi_bound   = hi;
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        n_settings++;
    endtask

    // Stimulus: directed table at reset bounds, then random phases over several bound settings.
    initial begin : stimulus
        logic [14:0] lo;
        logic [14:0] hi;
        t_pix_out    probe;
        for (int i = 0; i < 256; i++) begin
            gamma_lut[i] = gamma_expand(8'(i));
        end
        repeat (4) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) begin
            push_pixel(t_pix_in'({dir_rows[k].tag, dir_rows[k].r, dir_rows[k].g, dir_rows[k].b}),
                       dir_rows[k].typed,
                       t_pix_out'({dir_rows[k].tag, dir_rows[k].light, dir_rows[k].ok}));
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            drain_results();
            case (ph)
                0: begin lo = 15'd0; hi = LIGHT_MAX; end
                1: begin lo = 15'd0; hi = 15'd32767; end
                2: begin lo = 15'd32767; hi = 15'd32767; end
                3: begin
                    probe = predict_pix({16'd0, 8'd100, 8'd100, 8'd100});
                    lo    = probe.lightness;
                    probe = predict_pix({16'd0, 8'd200, 8'd200, 8'd200});
                    hi    = probe.lightness;
                end
                4: begin lo = LIGHT_MAX; hi = 15'd0; end
                default: begin lo = 15'($urandom); hi = 15'($urandom); end
            endcase
            set_bounds(lo, hi);
            // The second phase runs with no idling on either side.
            calm = (ph == 1);
            for (int n = 0; n < PHASE_WORDS; n++) begin
                if (ph == 3 && n == 60) begin
                    drain_results();
                end
                push_pixel(random_pixel(), 1'b0, '0);
            end
        end

        drain_results();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (awaited_out.size() != 0) begin
            flag_failure($sformatf("%0d results never arrived", awaited_out.size()));
        end
        $display("Covered %0d pixels over %0d bound settings, with bounds at 0, 25600 and 32767.",
                 n_sent, n_settings);
        $display("Checked %0d results, %0d inside bounds, lightness seen from %0d to %0d.",
                 n_checked, n_inside, light_lo, light_hi);
        if (n_errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Result side: check each word taken, pick the next ready, and hold off once for a long stretch.
    initial begin : result_sink
        int unsigned hold_left;
        bit          held_once;
        t_pix_out    want;
        hold_left = 0;
        held_once = 1'b0;
        while (!rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (o_out_valid && out_ready) begin
                n_checked++;
                if (o_out_pix.accepted) n_inside++;
                if (o_out_pix.lightness < light_lo) light_lo = o_out_pix.lightness;
                if (o_out_pix.lightness > light_hi) light_hi = o_out_pix.lightness;
                if (awaited_out.size() == 0) begin
                    flag_failure($sformatf("unexpected result word: tag %h light %0d flag %0b",
                                           o_out_pix.row_tag_out, o_out_pix.lightness,
                                           o_out_pix.accepted));
                end else begin
                    want = awaited_out.pop_front();
                    if (o_out_pix.row_tag_out !== want.row_tag_out
                            || o_out_pix.lightness !== want.lightness
                            || o_out_pix.accepted !== want.accepted) begin
                        flag_failure($sformatf(
                            "mismatch: expected tag %h light %0d flag %0b, got tag %h light %0d flag %0b",
                            want.row_tag_out, want.lightness, want.accepted,
                            o_out_pix.row_tag_out, o_out_pix.lightness, o_out_pix.accepted));
                    end
                end
            end
            if (hold_left != 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else if (!held_once && n_checked >= HOLD_AT) begin
                held_once = 1'b1;
                hold_left = HOLD_LEN - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= calm || ($urandom_range(99) >= 9);
            end
        end
    end

    // Watchdog: end the run when neither side has moved a word for too long.
    int unsigned quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((in_valid && o_in_ready) || (o_out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timeout: no word moved for %0d cycles.", STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

endmodule
